@@ hw/rtl/mdfr_pkg.sv @@
`timescale 1ns / 1ps

package mdfr_pkg;

   localparam int RING_DEPTH_DEF = 32;
   localparam int ID_W           = 32;
   localparam int TOPIC_W        = 3;
   localparam int HOP_W          = 8;
   localparam int RHOP_W         = 9;
   localparam int LIMIT_W        = 5;
   localparam int CSR_IDX_W      = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_SENSOR = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_ALERT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_PING   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_UAB    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_ECHO   = 3'd4;

   localparam logic [TOPIC_W-1:0] TOPIC_SENSOR = 3'd0;
   localparam logic [TOPIC_W-1:0] TOPIC_ALERT  = 3'd1;
   localparam logic [TOPIC_W-1:0] TOPIC_PING   = 3'd2;
   localparam logic [TOPIC_W-1:0] TOPIC_UAB    = 3'd3;
   localparam logic [TOPIC_W-1:0] TOPIC_ECHO   = 3'd4;

   localparam logic signed [LIMIT_W-1:0] LIMIT_SENSOR_RST = 5'sd2;
   localparam logic signed [LIMIT_W-1:0] LIMIT_ALERT_RST  = -5'sd1;
   localparam logic signed [LIMIT_W-1:0] LIMIT_PING_RST   = 5'sd3;
   localparam logic signed [LIMIT_W-1:0] LIMIT_UAB_RST    = 5'sd2;
   localparam logic signed [LIMIT_W-1:0] LIMIT_ECHO_RST   = 5'sd0;
   localparam logic signed [LIMIT_W-1:0] LIMIT_UNLIMITED  = -5'sd1;
   localparam logic signed [LIMIT_W-1:0] LIMIT_UNKNOWN    = 5'sd0;

   localparam logic FUNC_LOCAL = 1'b0;

   typedef enum logic [1:0] {
      VERDICT_DUP    = 2'd0,
      VERDICT_ACCEPT = 2'd1,
      VERDICT_RELAY  = 2'd2,
      VERDICT_LOCAL  = 2'd3
   } verdict_type;

   typedef struct packed {
      logic        capture;
      logic        scan_start;
      logic        scan_step;
      logic        write;
      logic        load;
      verdict_type verdict;
   } mdfr_cmd_type;

   typedef struct packed {
      logic local_send;
      logic scan_last;
      logic hit;
      logic relay;
   } mdfr_status_type;

endpackage

@@ hw/rtl/mdfr_if.sv @@
`timescale 1ns / 1ps

interface mdfr_req_if import mdfr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               func;
   logic [ID_W-1:0]    packet_id;
   logic [TOPIC_W-1:0] topic_code;
   logic [HOP_W-1:0]   hop_count;
   logic               hops_ok;

   modport source (output valid, func, packet_id, topic_code, hop_count, hops_ok,
                   input ready);
   modport sink   (input valid, func, packet_id, topic_code, hop_count, hops_ok,
                   output ready);
endinterface

interface mdfr_rsp_if import mdfr_pkg::*; ();
   logic              valid;
   logic              ready;
   verdict_type       verdict;
   logic [RHOP_W-1:0] relay_hops;
   logic [ID_W-1:0]   relay_id;

   modport source (output valid, verdict, relay_hops, relay_id, input ready);
   modport sink   (input valid, verdict, relay_hops, relay_id, output ready);
endinterface

@@ hw/rtl/mdfr_ram.sv @@
`timescale 1ns / 1ps

module mdfr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ hw/rtl/mdfr_dpath.sv @@
`timescale 1ns / 1ps

module mdfr_dpath import mdfr_pkg::*; #(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mdfr_cmd_type           cmd,
   output mdfr_status_type        status,
   input  logic                   req_func,
   input  logic [ID_W-1:0]        req_packet_id,
   input  logic [TOPIC_W-1:0]     req_topic_code,
   input  logic [HOP_W-1:0]       req_hop_count,
   input  logic                   req_hops_ok,
   output verdict_type            rsp_verdict,
   output logic [RHOP_W-1:0]      rsp_relay_hops,
   output logic [ID_W-1:0]        rsp_relay_id,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [LIMIT_W-1:0]     csr_wdata
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int FW = $clog2(RING_DEPTH + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);
   localparam logic [FW-1:0] FULL_FILL = FW'(RING_DEPTH);

   logic                      func_ff;
   logic [ID_W-1:0]           id_ff;
   logic [TOPIC_W-1:0]        topic_ff;
   logic [HOP_W-1:0]          hop_ff;
   logic                      hops_ok_ff;

   logic signed [LIMIT_W-1:0] lim_sensor_ff, lim_sensor_in;
   logic signed [LIMIT_W-1:0] lim_alert_ff, lim_alert_in;
   logic signed [LIMIT_W-1:0] lim_ping_ff, lim_ping_in;
   logic signed [LIMIT_W-1:0] lim_uab_ff, lim_uab_in;
   logic signed [LIMIT_W-1:0] lim_echo_ff, lim_echo_in;

   logic [AW-1:0]             head_ff, head_in;
   logic [FW-1:0]             fill_ff, fill_in;
   logic [AW-1:0]             scan_addr_ff, scan_addr_in;
   logic [AW-1:0]             cmp_addr_ff;
   logic                      cmp_pend_ff;
   logic                      hit_ff, hit_in;

   verdict_type               verdict_ff;
   logic [RHOP_W-1:0]         relay_hops_ff;
   logic [ID_W-1:0]           relay_id_ff;

   logic [ID_W-1:0]           rd_data;
   logic [ID_W-1:0]           entry;
   logic                      entry_match;
   logic signed [LIMIT_W-1:0] limit_sel;
   logic [RHOP_W-1:0]         hops_inc;
   logic                      relay;

   mdfr_ram #(
      .WIDTH (ID_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.write),
      .wr_addr (head_ff),
      .wr_data (id_ff),
      .rd_en   (cmd.scan_step),
      .rd_addr (scan_addr_ff),
      .rd_data (rd_data)
   );

   // Entries beyond the fill count have never been written and read as zero.
   always_comb begin
      entry       = (FW'(cmp_addr_ff) < fill_ff) ? rd_data : '0;
      entry_match = cmp_pend_ff && (entry == id_ff);
   end

   always_comb begin
      case (topic_ff)
         TOPIC_SENSOR: limit_sel = lim_sensor_ff;
         TOPIC_ALERT:  limit_sel = lim_alert_ff;
         TOPIC_PING:   limit_sel = lim_ping_ff;
         TOPIC_UAB:    limit_sel = lim_uab_ff;
         TOPIC_ECHO:   limit_sel = lim_echo_ff;
         default:      limit_sel = LIMIT_UNKNOWN;
      endcase
      hops_inc = {1'b0, hop_ff} + RHOP_W'(1);
      relay    = hops_ok_ff && ((limit_sel == LIMIT_UNLIMITED) ||
                 (!limit_sel[LIMIT_W-1] &&
                  (hops_inc < RHOP_W'(limit_sel[LIMIT_W-2:0]))));
   end

   always_comb begin
      status.local_send = (func_ff == FUNC_LOCAL);
      status.scan_last  = (scan_addr_ff == LAST_ADDR);
      status.hit        = hit_ff || entry_match;
      status.relay      = relay;
   end

   always_comb begin
      lim_sensor_in = lim_sensor_ff;
      lim_alert_in  = lim_alert_ff;
      lim_ping_in   = lim_ping_ff;
      lim_uab_in    = lim_uab_ff;
      lim_echo_in   = lim_echo_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LIMIT_SENSOR: lim_sensor_in = csr_wdata;
            CSR_LIMIT_ALERT:  lim_alert_in  = csr_wdata;
            CSR_LIMIT_PING:   lim_ping_in   = csr_wdata;
            CSR_LIMIT_UAB:    lim_uab_in    = csr_wdata;
            CSR_LIMIT_ECHO:   lim_echo_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (cmd.write) begin
         head_in = (head_ff == LAST_ADDR) ? '0 : head_ff + AW'(1);
         fill_in = (fill_ff == FULL_FILL) ? fill_ff : fill_ff + FW'(1);
      end
      scan_addr_in = scan_addr_ff;
      if (cmd.scan_start) begin
         scan_addr_in = '0;
      end else if (cmd.scan_step && (scan_addr_ff != LAST_ADDR)) begin
         scan_addr_in = scan_addr_ff + AW'(1);
      end
      hit_in = hit_ff;
      if (cmd.scan_start) begin
         hit_in = 1'b0;
      end else if (entry_match) begin
         hit_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_sensor_ff <= LIMIT_SENSOR_RST;
         lim_alert_ff  <= LIMIT_ALERT_RST;
         lim_ping_ff   <= LIMIT_PING_RST;
         lim_uab_ff    <= LIMIT_UAB_RST;
         lim_echo_ff   <= LIMIT_ECHO_RST;
         head_ff       <= '0;
         fill_ff       <= '0;
         scan_addr_ff  <= '0;
         cmp_pend_ff   <= 1'b0;
         hit_ff        <= 1'b0;
      end else begin
         lim_sensor_ff <= lim_sensor_in;
         lim_alert_ff  <= lim_alert_in;
         lim_ping_ff   <= lim_ping_in;
         lim_uab_ff    <= lim_uab_in;
         lim_echo_ff   <= lim_echo_in;
         head_ff       <= head_in;
         fill_ff       <= fill_in;
         scan_addr_ff  <= scan_addr_in;
         cmp_pend_ff   <= cmd.scan_step;
         hit_ff        <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff    <= req_func;
         id_ff      <= req_packet_id;
         topic_ff   <= req_topic_code;
         hop_ff     <= req_hop_count;
         hops_ok_ff <= req_hops_ok;
      end
      cmp_addr_ff <= scan_addr_ff;
      if (cmd.load) begin
         verdict_ff <= cmd.verdict;
         if (cmd.verdict == VERDICT_RELAY) begin
            relay_hops_ff <= hops_inc;
            relay_id_ff   <= id_ff;
         end else begin
            relay_hops_ff <= '0;
            relay_id_ff   <= '0;
         end
      end
   end

   assign rsp_verdict    = verdict_ff;
   assign rsp_relay_hops = relay_hops_ff;
   assign rsp_relay_id   = relay_id_ff;

endmodule

@@ hw/rtl/mdfr_ctrl.sv @@
`timescale 1ns / 1ps

module mdfr_ctrl import mdfr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  mdfr_status_type status,
   output mdfr_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_CHECK,
      ST_WRITE_FIRST,
      ST_WRITE_LAST,
      ST_FINISH
   } state_type;

   state_type   state_ff, state_in;
   verdict_type verdict_ff, verdict_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        out_free;

   always_comb begin
      state_in       = state_ff;
      verdict_in     = verdict_ff;
      rsp_valid_in   = rsp_valid_ff;
      out_free       = !rsp_valid_ff || rsp_ready;
      cmd.capture    = 1'b0;
      cmd.scan_start = 1'b0;
      cmd.scan_step  = 1'b0;
      cmd.write      = 1'b0;
      cmd.load       = 1'b0;
      cmd.verdict    = verdict_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.local_send) begin
               verdict_in = VERDICT_LOCAL;
               state_in   = ST_WRITE_LAST;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.hit) begin
               verdict_in = VERDICT_DUP;
               state_in   = ST_FINISH;
            end else begin
               state_in = ST_WRITE_FIRST;
            end
         end
         ST_WRITE_FIRST: begin
            cmd.write = 1'b1;
            if (status.relay) begin
               verdict_in = VERDICT_RELAY;
               state_in   = ST_WRITE_LAST;
            end else begin
               verdict_in = VERDICT_ACCEPT;
               state_in   = ST_FINISH;
            end
         end
         ST_WRITE_LAST: begin
            cmd.write = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         verdict_ff   <= VERDICT_DUP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         verdict_ff   <= verdict_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hw/rtl/mesh_duplicate_filter_relay.sv @@
// Channel    Dir   Ports                                   Handshake
// request    in    req_if: func, packet_id, topic_code,    valid/ready
//                  hop_count, hops_ok
// result     out   rsp_if: verdict, relay_hops, relay_id   valid/ready
// csr        in    csr_we, csr_index, csr_wdata            write enable only
//
// A local send goes from dispatch through one ring write to the finish state, which loads
// the result; a received packet is searched for in the ring and then goes on to finish as
// a duplicate, after one ring write when accepted or after two when relayed. The next
// request can be taken in the cycle after the load. The search reads one ring entry per
// cycle through the single read port of the ring memory.
// One request is in work at a time; a new request is taken while the previous result waits.
// Reset restores the hop limits and empties the ring through its fill count: no clearing pass.
// A stalled result holds the finished request until the result register is free.
`timescale 1ns / 1ps

module mesh_duplicate_filter_relay import mdfr_pkg::*; #(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   mdfr_req_if.sink             req_if,
   mdfr_rsp_if.source           rsp_if,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]   csr_wdata
);

   mdfr_cmd_type    cmd;
   mdfr_status_type status;

   mdfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mdfr_dpath #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_func       (req_if.func),
      .req_packet_id  (req_if.packet_id),
      .req_topic_code (req_if.topic_code),
      .req_hop_count  (req_if.hop_count),
      .req_hops_ok    (req_if.hops_ok),
      .rsp_verdict    (rsp_if.verdict),
      .rsp_relay_hops (rsp_if.relay_hops),
      .rsp_relay_id   (rsp_if.relay_id),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

`ifndef SYNTHESIS
   a_one_request_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request accepted while another is in work");

   a_scan_write_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.write && (cmd.scan_step || cmd.scan_start)))
      else $error("ring written during the duplicate search");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_if.valid || rsp_if.ready))
      else $error("result overwritten before it was taken");

   a_relay_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (rsp_if.verdict != VERDICT_RELAY))
         |-> ((rsp_if.relay_hops == '0) && (rsp_if.relay_id == '0)))
      else $error("relay fields set on a result that is not relayed");
`endif

endmodule

@@ dv/mdfr_relay_checker.sv @@
`timescale 1ns / 1ps

module mdfr_relay_checker import mdfr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   mdfr_req_if                  req_mon,
   mdfr_rsp_if                  rsp_mon,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]   csr_wdata,
   output int                   fail_count,
   output int                   pending,
   output int                   checked,
   output int                   dup_seen,
   output int                   relay_seen
);

   localparam int NUM_TOPICS = int'(TOPIC_ECHO) + 1;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      verdict_type       verdict;
      logic [RHOP_W-1:0] relay_hops;
      logic [ID_W-1:0]   relay_id;
   } outcome_type;

   logic signed [LIMIT_W-1:0] hop_limit [NUM_TOPICS];
   logic [ID_W-1:0]           seen_ring [RING_DEPTH_DEF];
   int                        ring_head;
   outcome_type               expected_q [$];
   int                        n_fail = 0;
   int                        n_checked = 0;
   int                        n_dup = 0;
   int                        n_relay = 0;

   function automatic void clear_state();
      hop_limit[TOPIC_SENSOR] = LIMIT_SENSOR_RST;
      hop_limit[TOPIC_ALERT]  = LIMIT_ALERT_RST;
      hop_limit[TOPIC_PING]   = LIMIT_PING_RST;
      hop_limit[TOPIC_UAB]    = LIMIT_UAB_RST;
      hop_limit[TOPIC_ECHO]   = LIMIT_ECHO_RST;
      foreach (seen_ring[i]) seen_ring[i] = '0;
      ring_head = 0;
      expected_q.delete();
   endfunction

   function automatic void record_id(input logic [ID_W-1:0] id);
      seen_ring[ring_head] = id;
      ring_head = (ring_head + 1) % RING_DEPTH_DEF;
   endfunction

   function automatic bit id_seen(input logic [ID_W-1:0] id);
      foreach (seen_ring[i]) begin
         if (seen_ring[i] == id) return 1'b1;
      end
      return 1'b0;
   endfunction

   // The ring is updated in request order, so the outcome is fixed at acceptance.
   function automatic outcome_type judge_packet(input logic func, input logic [ID_W-1:0] id,
                                                input logic [TOPIC_W-1:0] topic,
                                                input logic [HOP_W-1:0] hops, input logic ok);
      outcome_type res;
      int          lim;
      res = '0;
      if (func == FUNC_LOCAL) begin
         record_id(id);
         res.verdict = VERDICT_LOCAL;
      end else if (id_seen(id)) begin
         res.verdict = VERDICT_DUP;
      end else begin
         record_id(id);
         lim = (topic <= TOPIC_ECHO) ? int'(hop_limit[topic]) : int'(LIMIT_UNKNOWN);
         if (ok && (lim == int'(LIMIT_UNLIMITED) || int'(hops) + 1 < lim)) begin
            record_id(id);
            res.verdict    = VERDICT_RELAY;
            res.relay_hops = RHOP_W'(hops) + RHOP_W'(1);
            res.relay_id   = id;
         end else begin
            res.verdict = VERDICT_ACCEPT;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      if (reset) begin
         clear_state();
      end else begin
         if (csr_we && csr_index <= CSR_LIMIT_ECHO) begin
            hop_limit[csr_index] = csr_wdata;
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_q.push_back(judge_packet(req_mon.func, req_mon.packet_id,
                                              req_mon.topic_code, req_mon.hop_count,
                                              req_mon.hops_ok));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.verdict    = rsp_mon.verdict;
            got.relay_hops = rsp_mon.relay_hops;
            got.relay_id   = rsp_mon.relay_id;
            n_checked++;
            if (got.verdict == VERDICT_DUP) n_dup++;
            if (got.verdict == VERDICT_RELAY) n_relay++;
            if (expected_q.size() == 0) begin
               n_fail++;
               if (n_fail <= REPORT_MAX) begin
                  $display("%0t: unexpected result verdict %0d hops %0d id %h", $realtime,
                           got.verdict, got.relay_hops, got.relay_id);
               end
            end else begin
               want = expected_q.pop_front();
               if (got.verdict !== want.verdict || got.relay_hops !== want.relay_hops ||
                   got.relay_id !== want.relay_id) begin
                  n_fail++;
                  if (n_fail <= REPORT_MAX) begin
                     $display("%0t: result mismatch, expected verdict %0d hops %0d id %h",
                              $realtime, want.verdict, want.relay_hops, want.relay_id);
                     $display("%0t:                  got verdict %0d hops %0d id %h",
                              $realtime, got.verdict, got.relay_hops, got.relay_id);
                  end
               end
            end
         end
      end
      fail_count <= n_fail;
      pending    <= expected_q.size();
      checked    <= n_checked;
      dup_seen   <= n_dup;
      relay_seen <= n_relay;
   end

endmodule

@@ dv/tb_mesh_duplicate_filter_relay.sv @@
`timescale 1ns / 1ps

module tb_mesh_duplicate_filter_relay;
   import mdfr_pkg::*;

   localparam logic                 FUNC_RECEIVED       = ~FUNC_LOCAL;
   localparam logic [TOPIC_W-1:0]   TOPIC_FIRST_UNKNOWN = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED    = 3'd5;
   localparam int NUM_SETTINGS     = 6;
   localparam int RANDOM_PER_PHASE = 258;
   localparam int HOLD_CYCLES      = 400;
   localparam int CYCLE_LIMIT      = 600000;
   localparam int ID_POOL_DEPTH    = 48;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [LIMIT_W-1:0]   csr_wdata;
   bit                   steady_flow;
   bit                   pressure_on;
   int                   sent_count = 0;
   logic [ID_W-1:0]      recent_ids [$];

   int mismatches;
   int pending;
   int checked;
   int dups;
   int relays;

   mdfr_req_if req_ch ();
   mdfr_rsp_if rsp_ch ();

   mesh_duplicate_filter_relay uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mdfr_relay_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (mismatches),
      .pending    (pending),
      .checked    (checked),
      .dup_seen   (dups),
      .relay_seen (relays)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("mesh_duplicate_filter_relay test failed");
      $finish;
   end

   // The result side stalls at random, runs freely in the steady phase and holds off once
   // for a long stretch so that the block fills and refuses further requests.
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (pressure_on && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (steady_flow) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= 19);
         end
      end
   end

   task automatic send_request(input logic func, input logic [ID_W-1:0] id,
                               input logic [TOPIC_W-1:0] topic, input logic [HOP_W-1:0] hops,
                               input logic ok);
      int gap;
      gap = 0;
      if (!steady_flow) begin
         if ($urandom_range(0, 99) < 3) gap = $urandom_range(1, 45);
         else while ($urandom_range(0, 99) < 19) gap++;
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.func       <= func;
      req_ch.packet_id  <= id;
      req_ch.topic_code <= topic;
      req_ch.hop_count  <= hops;
      req_ch.hops_ok    <= ok;
      do @(posedge clock); while (!req_ch.ready);
      sent_count++;
   endtask

   task automatic send_random_request();
      logic                func;
      logic [ID_W-1:0]     id;
      logic [TOPIC_W-1:0]  topic;
      logic [HOP_W-1:0]    hops;
      int                  pick;
      func = ($urandom_range(0, 99) < 20) ? FUNC_LOCAL : FUNC_RECEIVED;
      pick = $urandom_range(0, 99);
      if (pick < 35 && recent_ids.size() > 0) begin
         id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
      end else if (pick < 40) begin
         id = $urandom_range(0, 1) ? '1 : '0;
      end else begin
         id = $urandom();
      end
      recent_ids.push_back(id);
      if (recent_ids.size() > ID_POOL_DEPTH) void'(recent_ids.pop_front());
      if ($urandom_range(0, 99) < 85) begin
         topic = TOPIC_W'($urandom_range(TOPIC_SENSOR, TOPIC_ECHO));
      end else begin
         topic = TOPIC_W'($urandom_range(TOPIC_FIRST_UNKNOWN, 2**TOPIC_W - 1));
      end
      if ($urandom_range(0, 1) != 0) hops = HOP_W'($urandom_range(0, 16));
      else hops = HOP_W'($urandom_range(0, 255));
      send_request(func, id, topic, hops, $urandom_range(0, 99) < 85);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CSR_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic apply_setting(input int phase);
      logic signed [LIMIT_W-1:0] val;
      for (int r = CSR_LIMIT_SENSOR; r <= CSR_LIMIT_ECHO; r++) begin
         case (phase)
            0: val = LIMIT_UNLIMITED;
            1: val = 5'sd15;
            2: val = 5'sd0;
            3: begin
               case (r)
                  CSR_LIMIT_SENSOR: val = -5'sd16;
                  CSR_LIMIT_ALERT:  val = -5'sd2;
                  CSR_LIMIT_PING:   val = 5'sd15;
                  CSR_LIMIT_UAB:    val = LIMIT_UNLIMITED;
                  default:          val = 5'sd1;
               endcase
            end
            4: val = LIMIT_W'($urandom_range(0, 16) - 1);
            default: val = LIMIT_W'($urandom_range(0, 2**LIMIT_W - 1));
         endcase
         write_limit(CSR_IDX_W'(r), val);
      end
      if (phase == 0 || phase == NUM_SETTINGS - 1) begin
         for (int r = CSR_FIRST_UNUSED; r < 2**CSR_IDX_W; r++) begin
            write_limit(CSR_IDX_W'(r), LIMIT_W'($urandom_range(0, 2**LIMIT_W - 1)));
         end
      end
      csr_we <= 1'b0;
   endtask

   initial begin
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.func       <= FUNC_LOCAL;
      req_ch.packet_id  <= '0;
      req_ch.topic_code <= TOPIC_SENSOR;
      req_ch.hop_count  <= '0;
      req_ch.hops_ok    <= 1'b0;
      csr_we            <= 1'b0;
      csr_index         <= CSR_LIMIT_SENSOR;
      csr_wdata         <= '0;
      steady_flow       <= 1'b0;
      pressure_on       <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset limits: sensor 2, alert unlimited, ping 3, uab 2, echo 0.
      send_request(FUNC_RECEIVED, '0, TOPIC_SENSOR, 8'd0, 1'b1);
      send_request(FUNC_RECEIVED, '1, TOPIC_ALERT, 8'd255, 1'b1);
      send_request(FUNC_RECEIVED, 32'd1, TOPIC_SENSOR, 8'd0, 1'b1);
      send_request(FUNC_RECEIVED, 32'd2, TOPIC_SENSOR, 8'd1, 1'b1);
      send_request(FUNC_RECEIVED, 32'd1, TOPIC_PING, 8'd0, 1'b1);
      send_request(FUNC_LOCAL, 32'h1234_5678, TOPIC_SENSOR, 8'd0, 1'b1);
      send_request(FUNC_RECEIVED, 32'h1234_5678, TOPIC_ALERT, 8'd0, 1'b1);
      send_request(FUNC_RECEIVED, 32'd3, TOPIC_PING, 8'd1, 1'b1);
      send_request(FUNC_RECEIVED, 32'd4, TOPIC_PING, 8'd2, 1'b1);
      send_request(FUNC_RECEIVED, 32'd5, TOPIC_UAB, 8'd0, 1'b1);
      send_request(FUNC_RECEIVED, 32'd6, TOPIC_ECHO, 8'd0, 1'b1);
      send_request(FUNC_RECEIVED, 32'd7, TOPIC_ALERT, 8'd0, 1'b0);
      for (int t = TOPIC_FIRST_UNKNOWN; t < 2**TOPIC_W; t++) begin
         send_request(FUNC_RECEIVED, ID_W'(32'd8 + t), TOPIC_W'(t), 8'd0, 1'b1);
      end
      send_request(FUNC_LOCAL, '0, TOPIC_ECHO, 8'd255, 1'b0);
      send_request(FUNC_RECEIVED, 32'h8000_0000, TOPIC_ALERT, 8'h80, 1'b1);
      send_request(FUNC_RECEIVED, 32'h5555_aaaa, TOPIC_ALERT, 8'h7f, 1'b1);
      send_request(FUNC_LOCAL, '1, TOPIC_UAB, 8'd0, 1'b1);
      send_request(FUNC_RECEIVED, '1, TOPIC_ALERT, 8'd0, 1'b1);

      for (int phase = 0; phase < NUM_SETTINGS; phase++) begin
         settle();
         apply_setting(phase);
         steady_flow <= (phase == 1);
         pressure_on <= (phase == 4);
         repeat (RANDOM_PER_PHASE) send_random_request();
      end
      settle();
      steady_flow <= 1'b0;
      repeat (RING_DEPTH_DEF + 10) @(posedge clock);

      $display("Sent %0d requests under the reset limits and %0d written limit settings;",
               sent_count, NUM_SETTINGS);
      $display("%0d results compared, %0d duplicates and %0d relays among them.",
               checked, dups, relays);
      if (mismatches == 0) begin
         $display("mesh_duplicate_filter_relay test passed");
      end else begin
         $display("mesh_duplicate_filter_relay test failed");
      end
      $finish;
   end

endmodule
